/* sv/tseq_pkg.sv */
// ----------------------------------------------------------------------------
// tseq_pkg: shared types and constants of the I2C transaction sequencer
// Opcodes, bus commands, TWI status codes, modes and the structs that travel
// between the sequencer modules.
// ----------------------------------------------------------------------------
package tseq_pkg;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_STATUS = 2'd1,
    OP_LOAD   = 2'd2
  } opcode_e;

  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_TX      = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5,
    CMD_ABORT   = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_WRITE      = 2'd0,
    MODE_READ       = 2'd1,
    MODE_WRITE_READ = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    REG_SLAVE_ADDR    = 2'd0,
    REG_TRANSFER_MODE = 2'd1,
    REG_SEND_LENGTH   = 2'd2,
    REG_RECV_LENGTH   = 2'd3
  } reg_idx_e;

  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RSTART      = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  localparam logic [7:0] IDLE_BYTE = 8'hFF;
  localparam logic [5:0] RX_MAX    = 6'd32;

  typedef struct packed {
    logic [6:0] slave_addr;
    logic [1:0] transfer_mode;
    logic [5:0] send_length;
    logic [5:0] recv_length;
  } cfg_t;

  typedef struct packed {
    opcode_e    opcode;
    logic [7:0] bus_status;
    logic [7:0] data_byte;
    logic [4:0] load_index;
  } item_t;

  typedef struct packed {
    cmd_e       bus_command;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [4:0] rx_index;
    logic [7:0] rx_byte;
    logic       busy_res;
    logic       transfer_done;
    logic       transfer_error;
    logic [5:0] received_count;
  } result_t;

  typedef struct packed {
    logic       en;
    logic [4:0] idx;
    logic [7:0] data;
  } store_wr_t;

endpackage

/* sv/tseq_ram.sv */
// ----------------------------------------------------------------------------
// tseq_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tseq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/tseq_core.sv */
// ----------------------------------------------------------------------------
// tseq_core: transaction state and per-event command decision
// Holds address byte, message index and busy flag; picks the bus command for
// the item in the input register.
// ----------------------------------------------------------------------------
module tseq_core
  import tseq_pkg::*;
#(
  parameter int BUF_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       exec_i,
  input  item_t      item_i,
  input  cfg_t       cfg_i,
  input  logic [7:0] store_data_i,
  output logic [5:0] msg_idx_d_o,
  output store_wr_t  store_wr_o,
  output result_t    result_o
);

  logic [7:0] addr_q, addr_d;
  logic [5:0] idx_q, idx_d;
  logic       busy_q, busy_d;

  logic       mode_read;
  logic       has_recv;
  logic       send_more;
  logic [5:0] recv_eff;
  logic [5:0] idx_inc;
  logic [5:0] idx_rx;
  logic       abort;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= '0;
      idx_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      addr_q <= addr_d;
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  assign mode_read = (cfg_i.transfer_mode == MODE_READ);
  assign has_recv  = (cfg_i.transfer_mode != MODE_WRITE);
  assign send_more = !mode_read && (idx_q < cfg_i.send_length) &&
                     (32'(idx_q) < BUF_DEPTH);
  assign idx_inc   = idx_q + 6'd1;

  always_comb begin
    if (cfg_i.recv_length == 6'd0) begin
      recv_eff = 6'd1;
    end else if (cfg_i.recv_length > RX_MAX) begin
      recv_eff = RX_MAX;
    end else begin
      recv_eff = cfg_i.recv_length;
    end
  end

  always_comb begin
    addr_d     = addr_q;
    idx_d      = idx_q;
    busy_d     = busy_q;
    abort      = 1'b0;
    idx_rx     = idx_q;
    store_wr_o = '{en: 1'b0, idx: item_i.load_index, data: item_i.data_byte};
    result_o   = '{bus_command: CMD_NONE, tx_byte: IDLE_BYTE, rx_valid: 1'b0,
                   rx_index: '0, rx_byte: '0, busy_res: 1'b0,
                   transfer_done: 1'b0, transfer_error: 1'b0,
                   received_count: '0};
    if (exec_i) begin
      unique case (item_i.opcode)
        OP_START: begin
          if (!busy_q) begin
            addr_d               = {cfg_i.slave_addr, mode_read};
            busy_d               = 1'b1;
            result_o.bus_command = CMD_START;
          end
        end
        OP_LOAD: begin
          store_wr_o.en = (32'(item_i.load_index) < BUF_DEPTH);
        end
        OP_STATUS: begin
          if (busy_q) begin
            unique case (item_i.bus_status)
              ST_START, ST_RSTART: begin
                idx_d                = '0;
                result_o.bus_command = CMD_TX;
                result_o.tx_byte     = addr_q;
              end
              ST_ARB_LOST: begin
                if (!mode_read) begin
                  addr_d[0] = 1'b0;
                end
                result_o.bus_command = CMD_START;
              end
              ST_SLA_W_ACK, ST_DATA_W_ACK: begin
                if (send_more) begin
                  result_o.bus_command = CMD_TX;
                  result_o.tx_byte     = store_data_i;
                  idx_d                = idx_inc;
                end else if (has_recv) begin
                  addr_d[0]            = 1'b1;
                  result_o.bus_command = CMD_START;
                end else begin
                  result_o.bus_command   = CMD_STOP;
                  result_o.transfer_done = 1'b1;
                  busy_d                 = 1'b0;
                end
              end
              ST_SLA_R_ACK, ST_DATA_R_ACK: begin
                if (!has_recv) begin
                  abort = 1'b1;
                end else begin
                  if (item_i.bus_status == ST_DATA_R_ACK) begin
                    result_o.rx_valid = 1'b1;
                    result_o.rx_index = idx_q[4:0];
                    result_o.rx_byte  = item_i.data_byte;
                    idx_rx            = idx_inc;
                  end
                  idx_d = idx_rx;
                  if (({1'b0, idx_rx} + 7'd1) < {1'b0, recv_eff}) begin
                    result_o.bus_command = CMD_RX_ACK;
                  end else begin
                    result_o.bus_command = CMD_RX_NACK;
                  end
                end
              end
              ST_DATA_R_NACK: begin
                if (!has_recv) begin
                  abort = 1'b1;
                end else begin
                  result_o.rx_valid       = 1'b1;
                  result_o.rx_index       = idx_q[4:0];
                  result_o.rx_byte        = item_i.data_byte;
                  idx_d                   = idx_inc;
                  result_o.received_count = idx_inc;
                  result_o.bus_command    = CMD_STOP;
                  result_o.transfer_done  = 1'b1;
                  busy_d                  = 1'b0;
                end
              end
              default: begin
                abort = 1'b1;
              end
            endcase
            if (abort) begin
              result_o.bus_command    = CMD_ABORT;
              result_o.transfer_done  = 1'b1;
              result_o.transfer_error = 1'b1;
              busy_d                  = 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
    result_o.busy_res = busy_d;
  end

  assign msg_idx_d_o = idx_d;

endmodule

/* sv/i2c_master_transaction_sequencer.sv */
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer: byte-level I2C master sequencer
// Turns start, load and bus status words into bus commands and received data.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one word per cycle while
//   in_ready_o is high: start a transaction, load a send byte, or a TWI bus
//   status with the received byte. Output channel (out_valid_o/out_ready_i)
//   returns exactly one result word per input word, in order: bus command,
//   byte to drive, received byte with its index, busy, done, error and count.
//   Config channel (cfg_valid_i/cfg_ready_o) is always ready; index selects
//   slave address, transfer mode, send length or receive length. Write it
//   only while no word is in flight.
//   An input word goes from the input register through the decision logic
//   into the result register. Throughput: one word per cycle while the
//   output is not stalled, set by the single pass through the decision logic.
//   The send store is a RAM with a registered read, read as a word is taken
//   with the next message index; a load in flight is forwarded to the read.
//   A stalled output holds its result; the input register still takes one
//   more word, then in_ready_o drops until the result is taken.
//   Reset clears both pipeline valid flags, the transaction state and the
//   config registers (receive length resets to one). Send store contents are
//   undefined until loaded.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer
  import tseq_pkg::*;
#(
  parameter int BUF_DEPTH = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] opcode_i,
  input  logic [7:0] bus_status_i,
  input  logic [7:0] data_byte_i,
  input  logic [4:0] load_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] bus_command_o,
  output logic [7:0] tx_byte_o,
  output logic       rx_valid_o,
  output logic [4:0] rx_index_o,
  output logic [7:0] rx_byte_o,
  output logic       busy_res_o,
  output logic       transfer_done_o,
  output logic       transfer_error_o,
  output logic [5:0] received_count_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

  cfg_t      cfg_q;
  item_t     item_q;
  logic      in_vld_q;
  result_t   res_q;
  logic      out_vld_q;
  logic      exec;
  logic      in_fire;
  result_t   res_d;
  store_wr_t store_wr;
  logic [5:0] msg_idx_d;
  logic [7:0] ram_rdata;
  logic [7:0] store_data;
  logic       byp_q;
  logic [7:0] byp_data_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [AW+5:0] rd_ext;
  logic [AW+4:0] wr_ext;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{slave_addr: '0, transfer_mode: MODE_WRITE, send_length: '0,
                 recv_length: 6'd1};
    end else if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_SLAVE_ADDR:    cfg_q.slave_addr    <= cfg_data_i[6:0];
        REG_TRANSFER_MODE: cfg_q.transfer_mode <= cfg_data_i[1:0];
        REG_SEND_LENGTH:   cfg_q.send_length   <= cfg_data_i[5:0];
        REG_RECV_LENGTH:   cfg_q.recv_length   <= cfg_data_i[5:0];
        default: begin
        end
      endcase
    end
  end

  assign exec       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || exec;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (exec) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= '{opcode: opcode_e'(opcode_i), bus_status: bus_status_i,
                  data_byte: data_byte_i, load_index: load_index_i};
    end
    if (exec) begin
      res_q <= res_d;
    end
  end

  tseq_core #(
    .BUF_DEPTH(BUF_DEPTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .exec_i      (exec),
    .item_i      (item_q),
    .cfg_i       (cfg_q),
    .store_data_i(store_data),
    .msg_idx_d_o (msg_idx_d),
    .store_wr_o  (store_wr),
    .result_o    (res_d)
  );

  assign rd_ext  = {{AW{1'b0}}, msg_idx_d};
  assign rd_addr = rd_ext[AW-1:0];
  assign wr_ext  = {{AW{1'b0}}, store_wr.idx};
  assign wr_addr = wr_ext[AW-1:0];

  tseq_ram #(
    .WIDTH(8),
    .DEPTH(BUF_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_wr.en),
    .waddr_i(wr_addr),
    .wdata_i(store_wr.data),
    .re_i   (in_fire),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_fire) begin
      byp_q <= store_wr.en && (wr_addr == rd_addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      byp_data_q <= store_wr.data;
    end
  end

  assign store_data = byp_q ? byp_data_q : ram_rdata;

  assign out_valid_o      = out_vld_q;
  assign bus_command_o    = res_q.bus_command;
  assign tx_byte_o        = res_q.tx_byte;
  assign rx_valid_o       = res_q.rx_valid;
  assign rx_index_o       = res_q.rx_index;
  assign rx_byte_o        = res_q.rx_byte;
  assign busy_res_o       = res_q.busy_res;
  assign transfer_done_o  = res_q.transfer_done;
  assign transfer_error_o = res_q.transfer_error;
  assign received_count_o = res_q.received_count;

endmodule

/* bench/i2c_master_transaction_sequencer_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_transaction_sequencer_tb: self-checking bench for the sequencer
// A directed table (idle and busy starts, extremes, arbitration loss, aborts,
// mode aliasing) followed by phases of protocol-shaped random words with some
// noise. Every result word is compared against a fixed row or a behavioral
// model, with random idling on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer_tb
  import tseq_pkg::*;
();

  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_WORDS = 125;
  localparam int NUM_PHASES  = 8;

  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam logic [1:0] MODE_ALIAS = 2'd3;

  localparam logic [7:0] ST_BUS_ERROR   = 8'h00;
  localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] ST_NO_INFO     = 8'hF8;

  typedef enum bit {ROW_WORD, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    logic [1:0] op;
    logic [7:0] st;
    logic [7:0] d;
    logic [4:0] li;
    reg_idx_e   ridx;
    bit         typed;
    result_t    want;
  } plan_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [1:0] opcode_i = '0;
  logic [7:0] bus_status_i = '0;
  logic [7:0] data_byte_i = '0;
  logic [4:0] load_index_i = '0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [2:0] bus_command_o;
  logic [7:0] tx_byte_o;
  logic       rx_valid_o;
  logic [4:0] rx_index_o;
  logic [7:0] rx_byte_o;
  logic       busy_res_o;
  logic       transfer_done_o;
  logic       transfer_error_o;
  logic [5:0] received_count_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [1:0] cfg_index_i = '0;
  logic [7:0] cfg_data_i = '0;

  // model of the sequencer
  logic [6:0] cfg_slave = '0;
  logic [1:0] cfg_mode = '0;
  logic [5:0] cfg_send = '0;
  logic [5:0] cfg_recv = 6'd1;
  logic [7:0] sq_addr_byte = '0;
  logic [5:0] sq_index = '0;
  logic       sq_busy = 1'b0;
  logic [7:0] send_bytes [32];
  bit         byte_loaded [32];

  result_t    pending_results [$];
  result_t    want;
  plan_row_t  plan [$];
  int         err_count = 0;
  int         hold_req = 0;
  bit         steady = 1'b0;
  bit         long_rx = 1'b0;
  int         noise_pct = 6;
  logic [7:0] next_status = ST_START;
  int unsigned quiet_cycles = 0;

  logic [7:0] noise_codes [10] = '{ST_ARB_LOST, ST_SLA_R_ACK, ST_DATA_R_ACK, ST_DATA_R_NACK,
                                   ST_SLA_W_ACK, ST_SLA_W_NACK, ST_DATA_W_NACK, ST_SLA_R_NACK,
                                   ST_BUS_ERROR, ST_NO_INFO};

  i2c_master_transaction_sequencer uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .bus_status_i     (bus_status_i),
    .data_byte_i      (data_byte_i),
    .load_index_i     (load_index_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .bus_command_o    (bus_command_o),
    .tx_byte_o        (tx_byte_o),
    .rx_valid_o       (rx_valid_o),
    .rx_index_o       (rx_index_o),
    .rx_byte_o        (rx_byte_o),
    .busy_res_o       (busy_res_o),
    .transfer_done_o  (transfer_done_o),
    .transfer_error_o (transfer_error_o),
    .received_count_o (received_count_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic int send_count_limit();
    if (cfg_mode == MODE_READ) return 0;
    return (cfg_send > 6'd32) ? 32 : int'(cfg_send);
  endfunction

  function automatic int recv_count_limit();
    int n;
    n = (cfg_recv == 6'd0) ? 1 : int'(cfg_recv);
    return (n > 32) ? 32 : n;
  endfunction

  function automatic void apply_reg(reg_idx_e idx, logic [7:0] val);
    case (idx)
      REG_SLAVE_ADDR:    cfg_slave = val[6:0];
      REG_TRANSFER_MODE: cfg_mode = val[1:0];
      REG_SEND_LENGTH:   cfg_send = val[5:0];
      REG_RECV_LENGTH:   cfg_recv = val[5:0];
      default: ;
    endcase
  endfunction

  function automatic result_t next_bus_action(logic [1:0] op, logic [7:0] st, logic [7:0] d,
                                              logic [4:0] li);
    result_t r;
    logic    give_up;
    r = '0;
    r.bus_command = CMD_NONE;
    r.tx_byte = IDLE_BYTE;
    give_up = 1'b0;
    if (op == OP_START) begin
      if (!sq_busy) begin
        sq_addr_byte = {cfg_slave, cfg_mode == MODE_READ};
        sq_busy = 1'b1;
        r.bus_command = CMD_START;
      end
    end else if (op == OP_LOAD) begin
      send_bytes[li] = d;
      byte_loaded[li] = 1'b1;
    end else if (op == OP_STATUS && sq_busy) begin
      case (st)
        ST_START, ST_RSTART: begin
          sq_index = '0;
          r.bus_command = CMD_TX;
          r.tx_byte = sq_addr_byte;
        end
        ST_ARB_LOST: begin
          if (cfg_mode != MODE_READ) sq_addr_byte[0] = 1'b0;
          r.bus_command = CMD_START;
        end
        ST_SLA_W_ACK, ST_DATA_W_ACK: begin
          if (int'(sq_index) < send_count_limit()) begin
            r.bus_command = CMD_TX;
            r.tx_byte = send_bytes[sq_index[4:0]];
            sq_index = sq_index + 6'd1;
          end else if (cfg_mode != MODE_WRITE) begin
            sq_addr_byte[0] = 1'b1;
            r.bus_command = CMD_START;
          end else begin
            r.bus_command = CMD_STOP;
            r.transfer_done = 1'b1;
            sq_busy = 1'b0;
          end
        end
        ST_SLA_R_ACK, ST_DATA_R_ACK: begin
          if (cfg_mode == MODE_WRITE) begin
            give_up = 1'b1;
          end else begin
            if (st == ST_DATA_R_ACK) begin
              r.rx_valid = 1'b1;
              r.rx_index = sq_index[4:0];
              r.rx_byte = d;
              sq_index = sq_index + 6'd1;
            end
            r.bus_command = (int'(sq_index) + 1 < recv_count_limit()) ? CMD_RX_ACK : CMD_RX_NACK;
          end
        end
        ST_DATA_R_NACK: begin
          if (cfg_mode == MODE_WRITE) begin
            give_up = 1'b1;
          end else begin
            r.rx_valid = 1'b1;
            r.rx_index = sq_index[4:0];
            r.rx_byte = d;
            sq_index = sq_index + 6'd1;
            r.received_count = sq_index;
            r.bus_command = CMD_STOP;
            r.transfer_done = 1'b1;
            sq_busy = 1'b0;
          end
        end
        default: give_up = 1'b1;
      endcase
      if (give_up) begin
        r.bus_command = CMD_ABORT;
        r.transfer_done = 1'b1;
        r.transfer_error = 1'b1;
        sq_busy = 1'b0;
      end
    end
    r.busy_res = sq_busy;
    return r;
  endfunction

  function automatic result_t mk_res(cmd_e c, logic [7:0] tx, int rv, int ri, int rb,
                                     int busy, int done, int err, int cnt);
    result_t r;
    r = '{c, tx, 1'(rv), 5'(ri), 8'(rb), 1'(busy), 1'(done), 1'(err), 6'(cnt)};
    return r;
  endfunction

  function automatic plan_row_t word_row(logic [1:0] op, logic [7:0] st, logic [7:0] d,
                                         logic [4:0] li);
    plan_row_t p;
    p.kind = ROW_WORD;
    p.op = op;
    p.st = st;
    p.d = d;
    p.li = li;
    p.ridx = REG_SLAVE_ADDR;
    p.typed = 1'b0;
    p.want = '0;
    return p;
  endfunction

  function automatic plan_row_t fixed_row(logic [1:0] op, logic [7:0] st, logic [7:0] d,
                                          logic [4:0] li, result_t w);
    plan_row_t p;
    p = word_row(op, st, d, li);
    p.typed = 1'b1;
    p.want = w;
    return p;
  endfunction

  function automatic plan_row_t reg_row(reg_idx_e idx, logic [7:0] val);
    plan_row_t p;
    p = word_row(OP_START, '0, val, '0);
    p.kind = ROW_REG;
    p.ridx = idx;
    return p;
  endfunction

  task automatic flag_error(string msg);
    if (err_count < 100) $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic cmp_field(string name, logic [7:0] got, logic [7:0] exp_val);
    if (got !== exp_val) flag_error($sformatf("%s got %0h exp %0h", name, got, exp_val));
  endtask

  // entered and left at a falling edge; valid stays up into the next word
  task automatic put_word(logic [1:0] op, logic [7:0] st, logic [7:0] d, logic [4:0] li,
                          bit typed, result_t fixed);
    result_t r;
    while (!steady && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    r = next_bus_action(op, st, d, li);
    case (r.bus_command)
      CMD_START:   next_status = ST_START;
      CMD_TX: begin
        if (st == ST_START || st == ST_RSTART)
          next_status = sq_addr_byte[0] ? ST_SLA_R_ACK : ST_SLA_W_ACK;
        else
          next_status = ST_DATA_W_ACK;
      end
      CMD_RX_ACK:  next_status = ST_DATA_R_ACK;
      CMD_RX_NACK: next_status = ST_DATA_R_NACK;
      default: ;
    endcase
    pending_results.push_back(typed ? fixed : r);
    in_valid_i <= 1'b1;
    opcode_i <= op;
    bus_status_i <= st;
    data_byte_i <= d;
    load_index_i <= li;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic put_cfg(reg_idx_e idx, logic [7:0] val);
    apply_reg(idx, val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic gen_word(output logic [1:0] op, output logic [7:0] st, output logic [7:0] d,
                          output logic [4:0] li);
    int pick;
    pick = $urandom_range(99);
    st = 8'($urandom);
    d = 8'($urandom);
    li = 5'($urandom);
    if (pick < 8) begin
      op = OP_LOAD;
    end else if (pick < 8 + noise_pct) begin
      op = 2'($urandom_range(3));
      if ($urandom_range(1) == 1) st = noise_codes[$urandom_range(9)];
    end else if (!sq_busy) begin
      op = OP_START;
    end else begin
      op = OP_STATUS;
      st = next_status;
      if (st == ST_START && $urandom_range(1) == 1)
        st = ST_RSTART;
      else if (st == ST_DATA_R_NACK && long_rx && $urandom_range(99) < 98)
        st = ST_DATA_R_ACK;
      if (!long_rx && $urandom_range(99) < 3) st = ST_ARB_LOST;
    end
    // never send a store entry that was not loaded: load it first
    if (op == OP_STATUS && sq_busy && (st == ST_SLA_W_ACK || st == ST_DATA_W_ACK) &&
        int'(sq_index) < send_count_limit() && !byte_loaded[sq_index[4:0]]) begin
      op = OP_LOAD;
      li = sq_index[4:0];
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (pending_results.size() == 0) begin
        flag_error("result word with nothing pending");
      end else begin
        want = pending_results.pop_front();
        cmp_field("bus_command", bus_command_o, want.bus_command);
        cmp_field("tx_byte", tx_byte_o, want.tx_byte);
        cmp_field("rx_valid", rx_valid_o, want.rx_valid);
        cmp_field("rx_index", rx_index_o, want.rx_index);
        cmp_field("rx_byte", rx_byte_o, want.rx_byte);
        cmp_field("busy_res", busy_res_o, want.busy_res);
        cmp_field("transfer_done", transfer_done_o, want.transfer_done);
        cmp_field("transfer_error", transfer_error_o, want.transfer_error);
        cmp_field("received_count", received_count_o, want.received_count);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles", STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_side
    bit hold_now;
    bit calm;
    int hold_seen;
    hold_seen = 0;
    forever begin
      @(posedge clk_i);
      hold_now = (hold_req != hold_seen);
      hold_seen = hold_req;
      calm = steady;
      @(negedge clk_i);
      if (hold_now) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      out_ready_i <= calm || ($urandom_range(99) >= 10);
    end
  end

  initial begin : word_side
    logic [1:0] op;
    logic [7:0] st;
    logic [7:0] d;
    logic [4:0] li;
    logic [7:0] vals [4];

    foreach (byte_loaded[j]) byte_loaded[j] = 1'b0;

    plan.push_back(fixed_row(OP_STATUS, ST_START, 8'h00, 5'd0,
                             mk_res(CMD_NONE, IDLE_BYTE, 0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(fixed_row(OP_UNKNOWN, 8'hFF, 8'hFF, 5'd31,
                             mk_res(CMD_NONE, IDLE_BYTE, 0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(fixed_row(OP_LOAD, 8'h00, 8'hA5, 5'd0,
                             mk_res(CMD_NONE, IDLE_BYTE, 0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(fixed_row(OP_LOAD, 8'hFF, 8'h00, 5'd31,
                             mk_res(CMD_NONE, IDLE_BYTE, 0, 0, 0, 0, 0, 0, 0)));
    plan.push_back(fixed_row(OP_START, 8'h00, 8'h00, 5'd0,
                             mk_res(CMD_START, IDLE_BYTE, 0, 0, 0, 1, 0, 0, 0)));
    plan.push_back(fixed_row(OP_START, 8'h00, 8'h00, 5'd0,
                             mk_res(CMD_NONE, IDLE_BYTE, 0, 0, 0, 1, 0, 0, 0)));
    plan.push_back(fixed_row(OP_STATUS, ST_START, 8'h00, 5'd0,
                             mk_res(CMD_TX, 8'h00, 0, 0, 0, 1, 0, 0, 0)));
    plan.push_back(fixed_row(OP_STATUS, ST_SLA_W_ACK, 8'h00, 5'd0,
                             mk_res(CMD_STOP, IDLE_BYTE, 0, 0, 0, 0, 1, 0, 0)));
    plan.push_back(reg_row(REG_SLAVE_ADDR, 8'h7F));
    plan.push_back(reg_row(REG_TRANSFER_MODE, 8'(MODE_WRITE_READ)));
    plan.push_back(reg_row(REG_SEND_LENGTH, 8'd2));
    plan.push_back(reg_row(REG_RECV_LENGTH, 8'd0));
    plan.push_back(word_row(OP_START, 8'h00, 8'h00, 5'd0));
    plan.push_back(word_row(OP_LOAD, 8'h00, 8'h3C, 5'd1));
    plan.push_back(word_row(OP_STATUS, ST_START, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_SLA_W_ACK, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_ARB_LOST, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_RSTART, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_SLA_W_ACK, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_DATA_W_ACK, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_DATA_W_ACK, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_RSTART, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_SLA_R_ACK, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_DATA_R_NACK, 8'h5A, 5'd0));
    plan.push_back(reg_row(REG_TRANSFER_MODE, 8'(MODE_READ)));
    plan.push_back(reg_row(REG_RECV_LENGTH, 8'd32));
    plan.push_back(word_row(OP_START, 8'h00, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_START, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_SLA_R_ACK, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_DATA_R_ACK, 8'h81, 5'd0));
    plan.push_back(fixed_row(OP_STATUS, ST_SLA_W_NACK, 8'h00, 5'd0,
                             mk_res(CMD_ABORT, IDLE_BYTE, 0, 0, 0, 0, 1, 1, 0)));
    plan.push_back(reg_row(REG_TRANSFER_MODE, 8'(MODE_WRITE)));
    plan.push_back(word_row(OP_START, 8'h00, 8'h00, 5'd0));
    plan.push_back(fixed_row(OP_STATUS, ST_DATA_R_ACK, 8'h00, 5'd0,
                             mk_res(CMD_ABORT, IDLE_BYTE, 0, 0, 0, 0, 1, 1, 0)));
    plan.push_back(reg_row(REG_TRANSFER_MODE, 8'(MODE_ALIAS)));
    plan.push_back(word_row(OP_START, 8'h00, 8'h00, 5'd0));
    plan.push_back(word_row(OP_STATUS, ST_DATA_R_NACK, 8'hC3, 5'd0));

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        if (i == 0 || plan[i-1].kind != ROW_REG) drain();
        put_cfg(plan[i].ridx, plan[i].d);
        if (i == plan.size() - 1 || plan[i+1].kind != ROW_REG) cfg_valid_i <= 1'b0;
      end else begin
        put_word(plan[i].op, plan[i].st, plan[i].d, plan[i].li, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: vals = '{8'h00, 8'(MODE_WRITE), 8'h00, 8'h00};
        1: vals = '{8'h7F, 8'(MODE_READ), 8'd32, 8'd32};
        2: vals = '{8'hFF, 8'hFE, 8'hFF, 8'hFF};
        4: vals = '{8'($urandom), 8'hFF, 8'($urandom_range(4)), 8'($urandom_range(4))};
        5: vals = '{8'($urandom), 8'(MODE_READ), 8'd0, 8'd32};
        default: begin
          vals[0] = 8'($urandom);
          vals[1] = 8'(($urandom_range(63) << 2) | $urandom_range(3));
          for (int k = 2; k < 4; k++)
            vals[k] = 8'(($urandom_range(3) << 6) |
                         (($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(6)));
        end
      endcase
      steady = (ph == 3);
      long_rx = (ph == 5);
      noise_pct = (ph == 5) ? 0 : 6;
      for (int k = 0; k < 4; k++) put_cfg(reg_idx_e'(k), vals[k]);
      cfg_valid_i <= 1'b0;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (ph == 2 && n == 40) hold_req++;
        gen_word(op, st, d, li);
        put_word(op, st, d, li, 1'b0, '0);
      end
    end

    drain();
    if (pending_results.size() != 0) flag_error("results still pending at end of run");
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/tseq_pkg.sv
sv/tseq_ram.sv
sv/tseq_core.sv
sv/i2c_master_transaction_sequencer.sv
bench/i2c_master_transaction_sequencer_tb.sv
